// ===== design/ivau_pkg.sv =====
// ----------------------------------------------------------------------------
// ivau_pkg
// Shared opcodes and sizing constants of the four-lane integer vector ALU.
// ----------------------------------------------------------------------------
package ivau_pkg;

   localparam int LANE_WIDTH_DEFAULT = 32;
   localparam int OPCODE_WIDTH       = 4;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_VADD   = 4'd0,
      OP_SADD   = 4'd1,
      OP_VSUB   = 4'd2,
      OP_SSUB   = 4'd3,
      OP_SCALE  = 4'd4,
      OP_DOT    = 4'd5,
      OP_CROSS  = 4'd6,
      OP_SDIV   = 4'd7,
      OP_NORMSQ = 4'd8,
      OP_EQUAL  = 4'd9
   } op_type;

endpackage

// ===== design/ivau_lane.sv =====
// ----------------------------------------------------------------------------
// ivau_lane
// One vector lane: add/subtract, two multipliers and a pipelined
// restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ivau_lane #(
   parameter int LANE_WIDTH = ivau_pkg::LANE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         advance,
   input  ivau_pkg::op_type             op,
   input  logic signed [LANE_WIDTH-1:0] a,
   input  logic signed [LANE_WIDTH-1:0] b,
   input  logic signed [LANE_WIDTH-1:0] s,
   input  logic signed [LANE_WIDTH-1:0] ca1,
   input  logic signed [LANE_WIDTH-1:0] cb1,
   input  logic signed [LANE_WIDTH-1:0] ca2,
   input  logic signed [LANE_WIDTH-1:0] cb2,
   output logic        [LANE_WIDTH-1:0] addsub,
   output logic        [LANE_WIDTH-1:0] m1,
   output logic        [LANE_WIDTH-1:0] m2,
   output logic        [LANE_WIDTH-1:0] quot,
   output logic                         eq
);
   import ivau_pkg::*;

   localparam int W = LANE_WIDTH;

   logic [W-1:0]   addsub_ff [0:W];
   logic [W-1:0]   m1_ff     [0:W];
   logic [W-1:0]   m2_ff     [0:W];
   logic           eq_ff     [0:W];
   logic           neg_ff    [0:W];
   logic [W-1:0]   rem_ff    [0:W];
   logic [W-1:0]   dvd_ff    [0:W];
   logic [W-1:0]   dvs_ff    [0:W];
   logic [W-1:0]   q_ff      [0:W];

   logic [W-1:0]   rem_in    [1:W];
   logic           qbit_in   [1:W];

   logic [W-1:0]   addsub_in;
   logic [W-1:0]   mx;
   logic [W-1:0]   my;
   logic [W-1:0]   p1;
   logic [W-1:0]   p2;
   logic [W-1:0]   abs_a;
   logic [W-1:0]   abs_s;

   always_comb begin
      case (op)
         OP_VADD: addsub_in = a + b;
         OP_SADD: addsub_in = a + s;
         OP_VSUB: addsub_in = a - b;
         OP_SSUB: addsub_in = a - s;
         default: addsub_in = '0;
      endcase
      case (op)
         OP_SCALE:  begin mx = a;   my = s;   end
         OP_DOT:    begin mx = a;   my = b;   end
         OP_NORMSQ: begin mx = a;   my = a;   end
         OP_CROSS:  begin mx = ca1; my = cb1; end
         default:   begin mx = '0;  my = '0;  end
      endcase
      p1    = mx * my;
      p2    = ca2 * cb2;
      abs_a = a[W-1] ? W'(-a) : W'(a);
      abs_s = s[W-1] ? W'(-s) : W'(s);
   end

   always_comb begin
      for (int k = 1; k <= W; k++) begin
         logic [W-1:0] sh;
         sh = {rem_ff[k-1][W-2:0], dvd_ff[k-1][W-1]};
         qbit_in[k] = (sh >= dvs_ff[k-1]);
         rem_in[k]  = qbit_in[k] ? sh - dvs_ff[k-1] : sh;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addsub_ff[0] <= addsub_in;
         m1_ff[0]     <= p1;
         m2_ff[0]     <= p2;
         eq_ff[0]     <= (a == b);
         neg_ff[0]    <= a[W-1] ^ s[W-1];
         rem_ff[0]    <= '0;
         dvd_ff[0]    <= abs_a;
         dvs_ff[0]    <= abs_s;
         q_ff[0]      <= '0;
         for (int k = 1; k <= W; k++) begin
            addsub_ff[k] <= addsub_ff[k-1];
            m1_ff[k]     <= m1_ff[k-1];
            m2_ff[k]     <= m2_ff[k-1];
            eq_ff[k]     <= eq_ff[k-1];
            neg_ff[k]    <= neg_ff[k-1];
            rem_ff[k]    <= rem_in[k];
            dvd_ff[k]    <= {dvd_ff[k-1][W-2:0], 1'b0};
            dvs_ff[k]    <= dvs_ff[k-1];
            q_ff[k]      <= {q_ff[k-1][W-2:0], qbit_in[k]};
         end
      end
   end

   assign addsub = addsub_ff[W];
   assign m1     = m1_ff[W];
   assign m2     = m2_ff[W];
   assign eq     = eq_ff[W];
   assign quot   = neg_ff[W] ? W'(-q_ff[W]) : q_ff[W];

endmodule

// ===== design/ivau_merge.sv =====
// ----------------------------------------------------------------------------
// ivau_merge
// Combines the four lane results by opcode into the registered response.
// ----------------------------------------------------------------------------
module ivau_merge #(
   parameter int LANE_WIDTH = ivau_pkg::LANE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         advance,
   input  ivau_pkg::op_type             op,
   input  logic                         szero,
   input  logic        [LANE_WIDTH-1:0] addsub [4],
   input  logic        [LANE_WIDTH-1:0] m1     [4],
   input  logic        [LANE_WIDTH-1:0] m2     [4],
   input  logic        [LANE_WIDTH-1:0] quot   [4],
   input  logic                         eq     [4],
   output logic signed [LANE_WIDTH-1:0] r      [4],
   output logic signed [LANE_WIDTH-1:0] scalar_out,
   output logic                         is_equal,
   output logic                         div_zero
);
   import ivau_pkg::*;

   localparam int W = LANE_WIDTH;

   logic [W-1:0] r_ff [4];
   logic [W-1:0] r_in [4];
   logic [W-1:0] sc_ff;
   logic [W-1:0] sc_in;
   logic         eq_ff;
   logic         dz_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         case (op) inside
            OP_VADD, OP_SADD, OP_VSUB, OP_SSUB: r_in[i] = addsub[i];
            OP_SCALE: r_in[i] = m1[i];
            OP_CROSS: r_in[i] = (i == 3) ? '0 : m1[i] - m2[i];
            OP_SDIV:  r_in[i] = szero ? '0 : quot[i];
            default:  r_in[i] = '0;
         endcase
      end
      sc_in = (op inside {OP_DOT, OP_NORMSQ}) ? m1[0] + m1[1] + m1[2] + m1[3] : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff  <= r_in;
         sc_ff <= sc_in;
         eq_ff <= (op == OP_EQUAL) && eq[0] && eq[1] && eq[2] && eq[3];
         dz_ff <= (op == OP_SDIV) && szero;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) r[i] = r_ff[i];
   end
   assign scalar_out = sc_ff;
   assign is_equal   = eq_ff;
   assign div_zero   = dz_ff;

endmodule

// ===== design/int4_vector_alu_unit.sv =====
// ----------------------------------------------------------------------------
// int4_vector_alu_unit
// Four-lane signed integer vector ALU with pipelined multiply and divide.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while no response is waiting or the waiting one
// is being taken; a request passes through one input stage, LANE_WIDTH divider
// stages that each resolve one quotient bit, and the merge register before its
// response becomes valid. The whole pipeline holds while a response waits to be
// taken.
module int4_vector_alu_unit #(
   parameter int LANE_WIDTH = ivau_pkg::LANE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_opcode,
   input  logic signed [LANE_WIDTH-1:0] req_a_x,
   input  logic signed [LANE_WIDTH-1:0] req_a_y,
   input  logic signed [LANE_WIDTH-1:0] req_a_z,
   input  logic signed [LANE_WIDTH-1:0] req_a_w,
   input  logic signed [LANE_WIDTH-1:0] req_b_x,
   input  logic signed [LANE_WIDTH-1:0] req_b_y,
   input  logic signed [LANE_WIDTH-1:0] req_b_z,
   input  logic signed [LANE_WIDTH-1:0] req_b_w,
   input  logic signed [LANE_WIDTH-1:0] req_scalar_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [LANE_WIDTH-1:0] rsp_r_x,
   output logic signed [LANE_WIDTH-1:0] rsp_r_y,
   output logic signed [LANE_WIDTH-1:0] rsp_r_z,
   output logic signed [LANE_WIDTH-1:0] rsp_r_w,
   output logic signed [LANE_WIDTH-1:0] rsp_scalar_out,
   output logic                         rsp_is_equal,
   output logic                         rsp_div_zero
);
   import ivau_pkg::*;

   localparam int W = LANE_WIDTH;

   logic         advance;
   logic         vld_ff   [0:W];
   op_type       op_ff    [0:W];
   logic         szero_ff [0:W];
   logic         rsp_valid_ff;

   logic [W-1:0] a   [4];
   logic [W-1:0] b   [4];
   logic [W-1:0] ca1 [4];
   logic [W-1:0] cb1 [4];
   logic [W-1:0] ca2 [4];
   logic [W-1:0] cb2 [4];
   logic [W-1:0] l_addsub [4];
   logic [W-1:0] l_m1     [4];
   logic [W-1:0] l_m2     [4];
   logic [W-1:0] l_quot   [4];
   logic         l_eq     [4];
   logic signed [W-1:0] r [4];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= W; k++) vld_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= W; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_valid_ff <= vld_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0]    <= op_type'(req_opcode);
         szero_ff[0] <= (req_scalar_in == '0);
         for (int k = 1; k <= W; k++) begin
            op_ff[k]    <= op_ff[k-1];
            szero_ff[k] <= szero_ff[k-1];
         end
      end
   end

   always_comb begin
      a[0] = req_a_x; a[1] = req_a_y; a[2] = req_a_z; a[3] = req_a_w;
      b[0] = req_b_x; b[1] = req_b_y; b[2] = req_b_z; b[3] = req_b_w;
      ca1[0] = req_a_y; cb1[0] = req_b_z; ca2[0] = req_a_z; cb2[0] = req_b_y;
      ca1[1] = req_a_z; cb1[1] = req_b_x; ca2[1] = req_a_x; cb2[1] = req_b_z;
      ca1[2] = req_a_x; cb1[2] = req_b_y; ca2[2] = req_a_y; cb2[2] = req_b_x;
      ca1[3] = '0;      cb1[3] = '0;      ca2[3] = '0;      cb2[3] = '0;
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      ivau_lane #(.LANE_WIDTH(W)) u_lane (
         .clock   (clock),
         .advance (advance),
         .op      (op_type'(req_opcode)),
         .a       (a[i]),
         .b       (b[i]),
         .s       (req_scalar_in),
         .ca1     (ca1[i]),
         .cb1     (cb1[i]),
         .ca2     (ca2[i]),
         .cb2     (cb2[i]),
         .addsub  (l_addsub[i]),
         .m1      (l_m1[i]),
         .m2      (l_m2[i]),
         .quot    (l_quot[i]),
         .eq      (l_eq[i])
      );
   end

   ivau_merge #(.LANE_WIDTH(W)) u_merge (
      .clock      (clock),
      .advance    (advance),
      .op         (op_ff[W]),
      .szero      (szero_ff[W]),
      .addsub     (l_addsub),
      .m1         (l_m1),
      .m2         (l_m2),
      .quot       (l_quot),
      .eq         (l_eq),
      .r          (r),
      .scalar_out (rsp_scalar_out),
      .is_equal   (rsp_is_equal),
      .div_zero   (rsp_div_zero)
   );

   assign rsp_r_x = r[0];
   assign rsp_r_y = r[1];
   assign rsp_r_z = r[2];
   assign rsp_r_w = r[3];

endmodule

// ===== tb/int4_vector_alu_unit_test.sv =====
// ----------------------------------------------------------------------------
// int4_vector_alu_unit_test
// Drives directed and random requests through the vector ALU with random
// idle gaps on both channels and checks every response against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module int4_vector_alu_unit_test;
   import ivau_pkg::*;

   localparam int LW = LANE_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 2 * (LW + 2) + 10;

   typedef logic [LW-1:0] lane_type;

   typedef struct packed {
      logic [3:0] opcode;
      lane_type   a_x, a_y, a_z, a_w;
      lane_type   b_x, b_y, b_z, b_w;
      lane_type   scalar;
   } alu_req_type;

   typedef struct packed {
      lane_type r_x, r_y, r_z, r_w;
      lane_type scalar_out;
      logic     is_equal;
      logic     div_zero;
   } alu_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [3:0] req_opcode = '0;
   lane_type   req_a_x = '0, req_a_y = '0, req_a_z = '0, req_a_w = '0;
   lane_type   req_b_x = '0, req_b_y = '0, req_b_z = '0, req_b_w = '0;
   lane_type   req_scalar_in = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   lane_type   rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_scalar_out;
   logic       rsp_is_equal, rsp_div_zero;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   int       errors = 0;
   int       accepted_reqs = 0;
   int       checked_rsps = 0;
   int       idle_cycles = 0;
   int       req_gap = 0;
   int       rsp_gap = 0;
   bit       req_accepted = 1'b0;
   bit       hold_off = 1'b0;
   bit       stim_done = 1'b0;
   bit [15:0] op_seen = '0;

   int4_vector_alu_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z), .req_a_w(req_a_w),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z), .req_b_w(req_b_w),
      .req_scalar_in(req_scalar_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z), .rsp_r_w(rsp_r_w),
      .rsp_scalar_out(rsp_scalar_out), .rsp_is_equal(rsp_is_equal),
      .rsp_div_zero(rsp_div_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic lane_type trunc_div(lane_type n, lane_type d);
      lane_type q;
      q = (n[LW-1] ? -n : n) / (d[LW-1] ? -d : d);
      return (n[LW-1] != d[LW-1]) ? -q : q;
   endfunction

   function automatic alu_rsp_type alu_predict(alu_req_type q);
      alu_rsp_type p;
      lane_type    a[4], b[4], r[4];
      a = '{q.a_x, q.a_y, q.a_z, q.a_w};
      b = '{q.b_x, q.b_y, q.b_z, q.b_w};
      r = '{default: '0};
      p = '0;
      case (q.opcode)
         OP_VADD:  foreach (r[i]) r[i] = a[i] + b[i];
         OP_SADD:  foreach (r[i]) r[i] = a[i] + q.scalar;
         OP_VSUB:  foreach (r[i]) r[i] = a[i] - b[i];
         OP_SSUB:  foreach (r[i]) r[i] = a[i] - q.scalar;
         OP_SCALE: foreach (r[i]) r[i] = a[i] * q.scalar;
         OP_DOT:   foreach (r[i]) p.scalar_out = p.scalar_out + lane_type'(a[i] * b[i]);
         OP_CROSS: begin
            r[0] = a[1] * b[2] - a[2] * b[1];
            r[1] = a[2] * b[0] - a[0] * b[2];
            r[2] = a[0] * b[1] - a[1] * b[0];
         end
         OP_SDIV: begin
            if (q.scalar == '0) p.div_zero = 1'b1;
            else foreach (r[i]) r[i] = trunc_div(a[i], q.scalar);
         end
         OP_NORMSQ: foreach (r[i]) p.scalar_out = p.scalar_out + lane_type'(a[i] * a[i]);
         OP_EQUAL:  p.is_equal = (a[0] == b[0]) && (a[1] == b[1]) &&
                                 (a[2] == b[2]) && (a[3] == b[3]);
         default: ;
      endcase
      p.r_x = r[0]; p.r_y = r[1]; p.r_z = r[2]; p.r_w = r[3];
      return p;
   endfunction

   function automatic lane_type rand_lane();
      case ($urandom_range(9))
         0: return {1'b1, {(LW-1){1'b0}}};
         1: return {1'b0, {(LW-1){1'b1}}};
         2: return '1;
         3: return '0;
         4: return lane_type'($urandom_range(16)) - lane_type'(8);
         default: return lane_type'($urandom);
      endcase
   endfunction

   function automatic alu_req_type rand_req();
      alu_req_type q;
      q.opcode = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9));
      q.a_x = rand_lane(); q.a_y = rand_lane(); q.a_z = rand_lane(); q.a_w = rand_lane();
      q.b_x = rand_lane(); q.b_y = rand_lane(); q.b_z = rand_lane(); q.b_w = rand_lane();
      q.scalar = rand_lane();
      if (q.opcode == OP_EQUAL && $urandom_range(1)) begin
         q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z; q.b_w = q.a_w;
         if ($urandom_range(1)) q.b_w = q.b_w ^ (lane_type'(1) << $urandom_range(LW-1));
      end
      if (q.opcode == OP_SDIV && $urandom_range(7) == 0) q.scalar = '0;
      return q;
   endfunction

   function automatic int rand_gap();
      int k;
      k = $urandom_range(99);
      if (k < 50) return 0;
      if (k < 90) return $urandom_range(3);
      return $urandom_range(40, 5);
   endfunction

   initial begin
      alu_req_type q;
      lane_type    mn, mx;
      mn = {1'b1, {(LW-1){1'b0}}};
      mx = {1'b0, {(LW-1){1'b1}}};
      for (int op = 0; op < 16; op++) begin
         q = '{opcode: 4'(op), a_x: mx, a_y: mn, a_z: '1, a_w: '0,
               b_x: mx, b_y: mn, b_z: '1, b_w: 1, scalar: mx};
         pending_reqs.push_back(q);
      end
      q = '{opcode: OP_SDIV, a_x: mn, a_y: mx, a_z: 7, a_w: -7,
            b_x: 0, b_y: 0, b_z: 0, b_w: 0, scalar: '1};
      pending_reqs.push_back(q);
      q.scalar = '0;
      pending_reqs.push_back(q);
      q.scalar = 2;
      pending_reqs.push_back(q);
      q = '{opcode: OP_EQUAL, a_x: mn, a_y: mx, a_z: '1, a_w: 5,
            b_x: mn, b_y: mx, b_z: '1, b_w: 5, scalar: 0};
      pending_reqs.push_back(q);
      q = '{opcode: OP_SCALE, a_x: mn, a_y: mx, a_z: '1, a_w: 3,
            b_x: 0, b_y: 0, b_z: 0, b_w: 0, scalar: mn};
      pending_reqs.push_back(q);
      repeat (2) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_reqs.size() == 0);
      for (int n = 0; n < 1500; n++) begin
         if (n == 750) begin
            wait (pending_reqs.size() == 0 && !req_valid);
            hold_off = 1'b1;
            wait (expected_rsps.size() == 0);
            hold_off = 1'b0;
         end
         pending_reqs.push_back(rand_req());
         if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 4);
      end
      stim_done = 1'b1;
   end

   // request and response-ready driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_accepted) begin
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !hold_off) begin
            alu_req_type q;
            q = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_opcode <= q.opcode;
            req_a_x <= q.a_x; req_a_y <= q.a_y; req_a_z <= q.a_z; req_a_w <= q.a_w;
            req_b_x <= q.b_x; req_b_y <= q.b_y; req_b_z <= q.b_z; req_b_w <= q.b_w;
            req_scalar_in <= q.scalar;
            req_gap <= rand_gap();
         end else begin
            req_valid <= 1'b0;
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap <= rand_gap();
         end
      end
   end

   // request and response monitor
   always @(posedge clock) begin
      if (!reset) begin
         req_accepted <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && req_ready) begin
            alu_req_type q;
            q = '{req_opcode, req_a_x, req_a_y, req_a_z, req_a_w,
                  req_b_x, req_b_y, req_b_z, req_b_w, req_scalar_in};
            expected_rsps.push_back(alu_predict(q));
            op_seen[req_opcode] = 1'b1;
            accepted_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            alu_rsp_type got, exp_rsp;
            got = '{rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_scalar_out,
                    rsp_is_equal, rsp_div_zero};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               checked_rsps++;
               if (got.r_x !== exp_rsp.r_x)
                  $display("%0t: r_x exp %h got %h", $time, exp_rsp.r_x, got.r_x);
               if (got.r_y !== exp_rsp.r_y)
                  $display("%0t: r_y exp %h got %h", $time, exp_rsp.r_y, got.r_y);
               if (got.r_z !== exp_rsp.r_z)
                  $display("%0t: r_z exp %h got %h", $time, exp_rsp.r_z, got.r_z);
               if (got.r_w !== exp_rsp.r_w)
                  $display("%0t: r_w exp %h got %h", $time, exp_rsp.r_w, got.r_w);
               if (got.scalar_out !== exp_rsp.scalar_out)
                  $display("%0t: scalar_out exp %h got %h", $time,
                           exp_rsp.scalar_out, got.scalar_out);
               if (got.is_equal !== exp_rsp.is_equal)
                  $display("%0t: is_equal exp %b got %b", $time,
                           exp_rsp.is_equal, got.is_equal);
               if (got.div_zero !== exp_rsp.div_zero)
                  $display("%0t: div_zero exp %b got %b", $time,
                           exp_rsp.div_zero, got.div_zero);
               if (got !== exp_rsp) errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done && pending_reqs.size() == 0 && !req_valid &&
            expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
         errors++;
      end
      $display("Covered %0d requests, %0d responses checked, opcode mask %b.",
               accepted_reqs, checked_rsps, op_seen);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: watchdog expired", $time);
      $display("FAIL");
      $finish;
   end

endmodule
